// ----- rtl/ftpt_pkg.sv -----
// package for the ftp command line tokenizer
// holds character codes, line status codes, the result struct and the verb helper
// no dependencies
`default_nettype none

package ftpt_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam int unsigned VERB_MAX = 4;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DONE    = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    typedef struct packed {
        t_status     line_status;
        logic        char_stored;
        logic [7:0]  char_value;
        logic [7:0]  char_index;
        logic [7:0]  line_length;
        logic [31:0] verb_text;
        logic [2:0]  verb_length;
        logic        param_present;
        logic [7:0]  param_offset;
    } t_result;

    // upper-case the first len bytes of raw, zero the rest
    function automatic logic [31:0] upper_verb(input logic [31:0] raw, input logic [2:0] len);
        logic [31:0] res;
        logic [7:0]  ch;
        res = '0;
        for (int i = 0; i < VERB_MAX; i++) begin
            ch = raw[8*i +: 8];
            if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
                ch = ch - CASE_OFFSET;
            end
            if (3'(i) < len) begin
                res[8*i +: 8] = ch;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ftpt_if.sv -----
// valid/ready channel interfaces for the ftp command line tokenizer
// depends on ftpt_pkg for the status type
`default_nettype none

interface ftpt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ftpt_result_if
    import ftpt_pkg::*;
;
    logic        valid;
    logic        ready;
    t_status     line_status;
    logic        char_stored;
    logic [7:0]  char_value;
    logic [7:0]  char_index;
    logic [7:0]  line_length;
    logic [31:0] verb_text;
    logic [2:0]  verb_length;
    logic        param_present;
    logic [7:0]  param_offset;

    modport source (
        output valid, output line_status, output char_stored, output char_value,
        output char_index, output line_length, output verb_text, output verb_length,
        output param_present, output param_offset, input ready
    );
    modport sink (
        input valid, input line_status, input char_stored, input char_value,
        input char_index, input line_length, input verb_text, input verb_length,
        input param_present, input param_offset, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/ftpt_line_state.sv -----
// line tracking state and per-byte decode of the ftp command line tokenizer
// depends on ftpt_pkg
`default_nettype none

module ftpt_line_state
    import ftpt_pkg::*;
#(
    parameter int unsigned LINE_MAX = 255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_result         o_result
);

    localparam logic [7:0] LineMaxB = 8'(LINE_MAX);

    logic [7:0]  r_char_count, n_char_count;
    logic [31:0] r_verb_chars, n_verb_chars;
    logic        r_space_seen, n_space_seen;
    logic [7:0]  r_first_space_pos, n_first_space_pos;
    logic        r_param_found, n_param_found;
    logic [7:0]  r_param_pos, n_param_pos;

    logic [7:0] c;
    logic [2:0] vlen;
    logic       clear;

    always_comb begin
        c = (i_byte == CH_BACKSLASH) ? CH_SLASH : i_byte;

        n_char_count      = r_char_count;
        n_verb_chars      = r_verb_chars;
        n_space_seen      = r_space_seen;
        n_first_space_pos = r_first_space_pos;
        n_param_found     = r_param_found;
        n_param_pos       = r_param_pos;
        clear             = 1'b0;
        vlen              = '0;
        o_result          = '0;
        o_result.line_status = ST_PENDING;

        if (c == CH_CR) begin
            // dropped
        end else if (c != CH_LF) begin
            if (r_char_count < LineMaxB) begin
                if (!r_space_seen) begin
                    if (c == CH_SPACE) begin
                        n_space_seen      = 1'b1;
                        n_first_space_pos = r_char_count;
                    end else if (r_char_count < 8'(VERB_MAX)) begin
                        n_verb_chars[8*r_char_count[1:0] +: 8] = c;
                    end
                end else if (!r_param_found && c != CH_SPACE) begin
                    n_param_found = 1'b1;
                    n_param_pos   = r_char_count;
                end
                n_char_count         = r_char_count + 8'd1;
                o_result.char_stored = 1'b1;
                o_result.char_value  = c;
                o_result.char_index  = r_char_count;
            end else begin
                clear                = 1'b1;
                o_result.line_status = ST_ERROR;
            end
        end else if (r_char_count == '0) begin
            o_result.line_status = ST_EMPTY;
        end else begin
            clear = 1'b1;
            if (r_space_seen ? (r_first_space_pos > 8'(VERB_MAX))
                             : (r_char_count > 8'(VERB_MAX))) begin
                o_result.line_status = ST_ERROR;
            end else begin
                vlen = r_space_seen ? r_first_space_pos[2:0] : r_char_count[2:0];
                o_result.line_status   = ST_DONE;
                o_result.line_length   = r_char_count;
                o_result.verb_text     = upper_verb(r_verb_chars, vlen);
                o_result.verb_length   = vlen;
                o_result.param_present = r_space_seen;
                o_result.param_offset  = (r_space_seen && r_param_found) ? r_param_pos
                                                                         : r_char_count;
            end
        end

        if (clear) begin
            n_char_count      = '0;
            n_verb_chars      = '0;
            n_space_seen      = 1'b0;
            n_first_space_pos = '0;
            n_param_found     = 1'b0;
            n_param_pos       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count      <= '0;
            r_verb_chars      <= '0;
            r_space_seen      <= 1'b0;
            r_first_space_pos <= '0;
            r_param_found     <= 1'b0;
            r_param_pos       <= '0;
        end else if (i_step) begin
            r_char_count      <= n_char_count;
            r_verb_chars      <= n_verb_chars;
            r_space_seen      <= n_space_seen;
            r_first_space_pos <= n_first_space_pos;
            r_param_found     <= n_param_found;
            r_param_pos       <= n_param_pos;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ftp_command_line_tokenizer_unit.sv -----
// top level of the ftp command line tokenizer
// depends on ftpt_pkg, ftpt_if (ftpt_byte_if, ftpt_result_if) and ftpt_line_state
//
// usage
//   i_rx carries one received byte per transaction; o_res carries exactly one
//   result transaction for every accepted byte, in order
//   a result reports a pending line with the echoed character (char_stored,
//   char_value, char_index; char_stored is low for a dropped CR), an empty line,
//   a completed line with verb, length and parameter offset, or a syntax error
// path: a byte accepted on i_rx lands in the input register, and its result is
//   loaded into the output register once that register is free, and it is
//   offered on o_res from the output register
// throughput: one byte per cycle while o_res.ready holds high; the line state
//   steps from the input register, so back-to-back bytes never wait on each other
// stall: when o_res.ready is low the output register holds its result, the
//   input register holds its byte, and i_rx.ready drops only once both are
//   full, so one more byte is still taken while a result waits
// reset: synchronous active low i_rst_n empties both registers and clears
//   the line state to an empty line
`default_nettype none

module ftp_command_line_tokenizer_unit
    import ftpt_pkg::*;
#(
    parameter int unsigned LINE_MAX = 255
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ftpt_byte_if.sink   i_rx,
    ftpt_result_if.source o_res
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // output register
    logic    r_out_valid;
    t_result r_out;

    t_result core_result;
    logic    out_load;
    logic    in_load;

    // output register frees when empty or when its transaction completes
    assign out_load = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_load  = i_rx.valid && i_rx.ready;
    assign i_rx.ready = !r_in_valid || out_load;

    ftpt_line_state #(
        .LINE_MAX (LINE_MAX)
    ) u_line_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (out_load),
        .i_byte   (r_in_byte),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (out_load) begin
            r_out <= core_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.line_status   = r_out.line_status;
    assign o_res.char_stored   = r_out.char_stored;
    assign o_res.char_value    = r_out.char_value;
    assign o_res.char_index    = r_out.char_index;
    assign o_res.line_length   = r_out.line_length;
    assign o_res.verb_text     = r_out.verb_text;
    assign o_res.verb_length   = r_out.verb_length;
    assign o_res.param_present = r_out.param_present;
    assign o_res.param_offset  = r_out.param_offset;

endmodule

`default_nettype wire
